FILE: sv/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and constants for the heading controller
// Register indexes, reset values, the arctangent table and the control
// struct that travels with each transaction down the pipeline.
// ----------------------------------------------------------------------------
package hpc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADING_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_HEADING_GAIN      = 2'd1;
  localparam logic [1:0] CFG_CRUISE_SPEED      = 2'd2;

  // reset values: pi/6, 5.0 in Q4.8, 1.5 in Q8.8
  localparam logic [14:0] THRESHOLD_RESET = 15'd5461;
  localparam logic [11:0] GAIN_RESET      = 12'd1280;
  localparam logic [15:0] CRUISE_RESET    = 16'd384;

  // binary angle of pi, start angle after the half-turn pre-rotation
  localparam logic [15:0] ANGLE_PI = 16'h8000;

  // round(atan(2^-i) * 32768 / pi)
  localparam logic [15:0] ATAN_TABLE [32] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
  };

  typedef struct packed {
    logic valid;  // stage holds a transaction
    logic zero;   // goal at the origin, bearing forced to 0
  } hpc_ctrl_t;

endpackage

FILE: sv/hpc_cordic_cell.sv
// ----------------------------------------------------------------------------
// hpc_cordic_cell: one vectoring micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-STAGE) and accumulates the
// angle; one register stage per cell.
// ----------------------------------------------------------------------------
module hpc_cordic_cell #(
  parameter int IW    = 27,
  parameter int STAGE = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hpc_pkg::hpc_ctrl_t     ctrl_i,
  input  logic signed [IW-1:0]   x_i,
  input  logic signed [IW-1:0]   y_i,
  input  logic        [15:0]     z_i,
  input  logic        [15:0]     heading_i,
  output hpc_pkg::hpc_ctrl_t     ctrl_o,
  output logic signed [IW-1:0]   x_o,
  output logic signed [IW-1:0]   y_o,
  output logic        [15:0]     z_o,
  output logic        [15:0]     heading_o
);

  localparam logic [15:0] ATAN = hpc_pkg::ATAN_TABLE[STAGE];

  hpc_pkg::hpc_ctrl_t    ctrl_q;
  logic signed [IW-1:0]  x_d, y_d, x_q, y_q, xs, ys;
  logic        [15:0]    z_d, z_q, heading_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[IW-1]) begin
      // clockwise
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    heading_q <= heading_i;
  end

  assign ctrl_o    = ctrl_q;
  assign x_o       = x_q;
  assign y_o       = y_q;
  assign z_o       = z_q;
  assign heading_o = heading_q;

endmodule

FILE: sv/hpc_output_stage.sv
// ----------------------------------------------------------------------------
// hpc_output_stage: heading error, gain and speed decision
// Two register stages: bearing and wrapped error, then the gain product,
// the threshold compare and the result strobe.
// ----------------------------------------------------------------------------
module hpc_output_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpc_pkg::hpc_ctrl_t ctrl_i,
  input  logic [15:0]        z_i,
  input  logic [15:0]        heading_i,
  input  logic [14:0]        threshold_i,
  input  logic [11:0]        gain_i,
  input  logic [15:0]        cruise_i,
  output logic               done_o,
  output logic [15:0]        forward_speed_o,
  output logic signed [19:0] turn_rate_o,
  output logic signed [15:0] bearing_o
);

  logic               err_valid_q, done_q;
  logic [15:0]        bearing_d, bearing_q, err_d;
  logic signed [15:0] err_q;
  logic [16:0]        mag;
  logic signed [28:0] prod;
  logic [15:0]        speed_q;
  logic signed [19:0] rate_q;
  logic signed [15:0] bearing_out_q;

  // stage 1: bearing and error wrapped to 16 bits
  always_comb begin
    bearing_d = ctrl_i.zero ? 16'd0 : z_i;
    err_d     = bearing_d - heading_i;
  end

  // stage 2: absolute error and gain product
  always_comb begin
    mag  = err_q[15] ? (17'd0 - {err_q[15], err_q}) : {1'b0, err_q};
    prod = err_q * $signed({1'b0, gain_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      err_valid_q <= ctrl_i.valid;
      done_q      <= err_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q     <= bearing_d;
    err_q         <= $signed(err_d);
    speed_q       <= (mag > {2'b00, threshold_i}) ? 16'd0 : cruise_i;
    rate_q        <= prod[27:8];
    bearing_out_q <= $signed(bearing_q);
  end

  assign done_o          = done_q;
  assign forward_speed_o = speed_q;
  assign turn_rate_o     = rate_q;
  assign bearing_o       = bearing_out_q;

endmodule

FILE: sv/heading_p_controller.sv
// ----------------------------------------------------------------------------
// heading_p_controller: proportional heading controller with CORDIC atan2
// Computes the bearing to a goal point, the heading error and the speed and
// turn-rate commands, fully pipelined.
// ----------------------------------------------------------------------------
// A new goal/heading transaction is taken in every clock cycle (busy_o stays
// low), and each one gives exactly one result, registered in turn by the
// half-turn pre-rotation, each CORDIC cell and the output stage (error,
// then gain product and threshold compare). The result is shown for a single
// cycle with done_o high and the receiver cannot stall it, so it must take
// every strobe. Configuration writes are always accepted (cfg_ready_o high)
// and should be made only while no transaction is in flight; writes to an
// index past the last register are ignored.
module heading_p_controller #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [23:0] goal_x_i,
  input  logic signed [23:0] goal_y_i,
  input  logic signed [15:0] heading_i,
  // results
  output logic               done_o,
  output logic [15:0]        forward_speed_o,
  output logic signed [19:0] turn_rate_o,
  output logic signed [15:0] bearing_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // headroom for the half-turn negation and the cordic gain of about 1.65
  localparam int IW = COORD_WIDTH + 3;

  // configuration registers
  logic [14:0] threshold_q;
  logic [11:0] gain_q;
  logic [15:0] cruise_q;

  // pipeline is never blocked
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= hpc_pkg::THRESHOLD_RESET;
      gain_q      <= hpc_pkg::GAIN_RESET;
      cruise_q    <= hpc_pkg::CRUISE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hpc_pkg::CFG_HEADING_THRESHOLD: threshold_q <= cfg_data_i[14:0];
        hpc_pkg::CFG_HEADING_GAIN:      gain_q      <= cfg_data_i[11:0];
        hpc_pkg::CFG_CRUISE_SPEED:      cruise_q    <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // coordinate conditioning: sign-extend to 32, keep the low COORD_WIDTH bits
  logic [31:0]            ext_x, ext_y;
  logic [COORD_WIDTH-1:0] cx, cy;
  logic signed [IW-1:0]   wx, wy;

  always_comb begin
    ext_x = {{8{goal_x_i[23]}}, goal_x_i};
    ext_y = {{8{goal_y_i[23]}}, goal_y_i};
    cx    = ext_x[COORD_WIDTH-1:0];
    cy    = ext_y[COORD_WIDTH-1:0];
    wx    = $signed({{3{cx[COORD_WIDTH-1]}}, cx});
    wy    = $signed({{3{cy[COORD_WIDTH-1]}}, cy});
  end

  // pre-rotation stage: left half-plane is turned by pi so x >= 0
  hpc_pkg::hpc_ctrl_t   pre_ctrl_q;
  logic signed [IW-1:0] pre_x_q, pre_y_q;
  logic        [15:0]   pre_z_q, pre_heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_ctrl_q <= '0;
    end else begin
      pre_ctrl_q.valid <= start_i && !busy_o;
      pre_ctrl_q.zero  <= (cx == '0) && (cy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wx[IW-1]) begin
      pre_x_q <= -wx;
      pre_y_q <= -wy;
      pre_z_q <= hpc_pkg::ANGLE_PI;
    end else begin
      pre_x_q <= wx;
      pre_y_q <= wy;
      pre_z_q <= 16'd0;
    end
    pre_heading_q <= heading_i;
  end

  // chain of cordic cells, tap 0 is the pre-rotation register
  hpc_pkg::hpc_ctrl_t   cell_ctrl    [CORDIC_STAGES+1];
  logic signed [IW-1:0] cell_x       [CORDIC_STAGES+1];
  logic signed [IW-1:0] cell_y       [CORDIC_STAGES+1];
  logic        [15:0]   cell_z       [CORDIC_STAGES+1];
  logic        [15:0]   cell_heading [CORDIC_STAGES+1];

  assign cell_ctrl[0]    = pre_ctrl_q;
  assign cell_x[0]       = pre_x_q;
  assign cell_y[0]       = pre_y_q;
  assign cell_z[0]       = pre_z_q;
  assign cell_heading[0] = pre_heading_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    hpc_cordic_cell #(
      .IW    (IW),
      .STAGE (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl[g]),
      .x_i       (cell_x[g]),
      .y_i       (cell_y[g]),
      .z_i       (cell_z[g]),
      .heading_i (cell_heading[g]),
      .ctrl_o    (cell_ctrl[g+1]),
      .x_o       (cell_x[g+1]),
      .y_o       (cell_y[g+1]),
      .z_o       (cell_z[g+1]),
      .heading_o (cell_heading[g+1])
    );
  end

  // error, gain and speed decision
  hpc_output_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (cell_ctrl[CORDIC_STAGES]),
    .z_i             (cell_z[CORDIC_STAGES]),
    .heading_i       (cell_heading[CORDIC_STAGES]),
    .threshold_i     (threshold_q),
    .gain_i          (gain_q),
    .cruise_i        (cruise_q),
    .done_o          (done_o),
    .forward_speed_o (forward_speed_o),
    .turn_rate_o     (turn_rate_o),
    .bearing_o       (bearing_o)
  );

  // a transaction leaving the last cell is delivered through the output stage's error and result registers
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl[CORDIC_STAGES].valid |-> ##2 done_o)
    else $error("result strobe missing after cordic chain");

  // nothing is delivered that did not leave the chain
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cell_ctrl[CORDIC_STAGES].valid |-> ##2 !done_o)
    else $error("result strobe without transaction");

  // after the half-turn the vector stays in the right half-plane
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl[CORDIC_STAGES].valid |-> !cell_x[CORDIC_STAGES][IW-1])
    else $error("cordic x went negative");

  // speed command is either stop or cruise
  a_speed_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (forward_speed_o == 16'd0) || (forward_speed_o == cruise_q))
    else $error("forward speed neither zero nor cruise");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for heading_p_controller
// Drives goal/heading transactions in random bursts, predicts bearing, turn
// rate and forward speed with a CORDIC model of its own, and checks every
// result strobe in order. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF       = 4;
  localparam int RST_CYCLES     = 3;
  localparam int CORDIC_STAGES  = 16;
  localparam int PIPE_LATENCY   = CORDIC_STAGES + 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 160;
  localparam int WARMUP_ITEMS   = 60;
  localparam int MAX_REPORTS    = 40;

  // no register lives at this index, writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // per-stage rotation angle in binary-angle units
  localparam int ARCTAN_LUT [CORDIC_STAGES] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81,
    41,   20,   10,   5,    3,   1,   1,   0
  };

  typedef struct packed {
    logic signed [23:0] gx;
    logic signed [23:0] gy;
    logic signed [15:0] hd;
  } goal_t;

  typedef struct packed {
    logic [15:0]        speed;
    logic signed [19:0] rate;
    logic signed [15:0] bearing;
  } steer_cmd_t;

  typedef struct packed {
    goal_t      goal;
    steer_cmd_t cmd;
  } expected_cmd_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // command channel
  logic               start   = 1'b0;
  logic               busy;
  logic signed [23:0] goal_x  = '0;
  logic signed [23:0] goal_y  = '0;
  logic signed [15:0] heading = '0;

  // result channel
  logic               done;
  logic [15:0]        res_speed;
  logic signed [19:0] res_rate;
  logic signed [15:0] res_bearing;

  // register write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = hpc_pkg::CFG_HEADING_THRESHOLD;
  logic [15:0] cfg_data  = '0;

  // predictor's copy of the registers
  logic [14:0] thr_lim   = hpc_pkg::THRESHOLD_RESET;
  logic [11:0] turn_gain = hpc_pkg::GAIN_RESET;
  logic [15:0] cruise    = hpc_pkg::CRUISE_RESET;

  // goals waiting to be sent, commands waiting to come back
  goal_t         goal_q [$];
  expected_cmd_t cmd_q  [$];

  // driver state
  goal_t cur_goal;
  bit    holding    = 1'b0;
  int    burst_left = 1;
  int    gap_left   = 0;

  // bookkeeping
  expected_cmd_t accepted_cmd;
  expected_cmd_t oldest;
  int n_items      = 0;
  int n_results    = 0;
  int n_stopped    = 0;
  int n_cfg_writes = 0;
  int n_errors     = 0;
  int idle_cycles  = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  heading_p_controller u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .goal_x_i        (goal_x),
    .goal_y_i        (goal_y),
    .heading_i       (heading),
    .done_o          (done),
    .forward_speed_o (res_speed),
    .turn_rate_o     (res_rate),
    .bearing_o       (res_bearing),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // vectoring cordic, half-turn pre-rotation when the goal lies behind
  function automatic logic signed [15:0] goal_bearing(input logic signed [23:0] gx,
                                                      input logic signed [23:0] gy);
    longint x, y, z, xs, ys;
    x = gx;
    y = gy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = -32768;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_LUT[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_LUT[i];
      end
    end
    return z[15:0];
  endfunction

  // error wraps in 16 bits, speed gated by |error|, rate is error * gain / 256
  function automatic steer_cmd_t steer_command(input goal_t g);
    steer_cmd_t         c;
    logic signed [15:0] err;
    int                 mag;
    longint             prod;
    c.bearing = goal_bearing(g.gx, g.gy);
    err       = c.bearing - g.hd;
    mag       = (err < 0) ? -int'(err) : int'(err);
    c.speed   = (mag > int'(thr_lim)) ? 16'd0 : cruise;
    prod      = longint'(err) * longint'(turn_gain);
    c.rate    = 20'(prod >>> 8);
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic signed [23:0] random_coord();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4:    v = 24'(int'($urandom_range(0, 32)) - 16);
      5:       v = '0;
      6: begin
        case ($urandom_range(0, 3))
          0:       v = 24'sh7fffff;
          1:       v = 24'sh800000;
          2:       v = 24'sd1;
          default: v = -24'sd1;
        endcase
      end
      default: v = v >>> $urandom_range(1, 22);
    endcase
    return v;
  endfunction

  // heading often placed right around the threshold, or exactly half a turn off
  function automatic goal_t random_goal();
    goal_t              g;
    logic signed [15:0] b;
    int                 d;
    g.gx = random_coord();
    g.gy = random_coord();
    b    = goal_bearing(g.gx, g.gy);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: g.hd = 16'($urandom);
      4, 5, 6, 7: begin
        d = int'(thr_lim) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) d = -d;
        g.hd = b - d[15:0];
      end
      8:       g.hd = b ^ hpc_pkg::ANGLE_PI;
      default: g.hd = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
    return g;
  endfunction

  task automatic push_goal(input int gx, input int gy, input int hd);
    goal_t g;
    g.gx = gx[23:0];
    g.gy = gy[23:0];
    g.hd = hd[15:0];
    goal_q.push_back(g);
  endtask

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  // register write; predictor copy follows at the accepting edge
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hpc_pkg::CFG_HEADING_THRESHOLD: thr_lim   = data[14:0];
      hpc_pkg::CFG_HEADING_GAIN:      turn_gain = data[11:0];
      hpc_pkg::CFG_CRUISE_SPEED:      cruise    = data;
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  // sender stays quiet until the pipe is empty and every result is back
  task automatic wait_drained();
    do @(negedge clk); while (goal_q.size() != 0 || holding || cmd_q.size() != 0);
  endtask

  // one register setting per phase: extremes and reset values first, then random ones
  task automatic program_phase(input int p);
    logic [15:0] vals [4];
    logic [1:0]  ord  [3];
    logic [1:0]  tmp;
    int          r;
    case (p)
      0: vals = '{16'd0, 16'd0, 16'd0, 16'd0};
      1: vals = '{16'hffff, 16'hffff, 16'hffff, 16'd0};
      2: vals = '{16'd1, 16'd1, 16'd1, 16'd0};
      3: vals = '{16'(hpc_pkg::THRESHOLD_RESET), 16'(hpc_pkg::GAIN_RESET),
                  hpc_pkg::CRUISE_RESET, 16'd0};
      default: begin
        vals[hpc_pkg::CFG_HEADING_THRESHOLD] = (p % 2) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 16383));
        vals[hpc_pkg::CFG_HEADING_GAIN]      = 16'($urandom);
        vals[hpc_pkg::CFG_CRUISE_SPEED]      = 16'($urandom);
        vals[CFG_UNUSED]                     = '0;
      end
    endcase
    ord[0] = hpc_pkg::CFG_HEADING_THRESHOLD;
    ord[1] = hpc_pkg::CFG_HEADING_GAIN;
    ord[2] = hpc_pkg::CFG_CRUISE_SPEED;
    for (int j = 2; j > 0; j--) begin
      r      = $urandom_range(0, j);
      tmp    = ord[j];
      ord[j] = ord[r];
      ord[r] = tmp;
    end
    // stray write to the empty index, must not disturb anything
    if ($urandom_range(0, 1)) cfg_write(CFG_UNUSED, 16'($urandom));
    for (int j = 0; j < 3; j++) cfg_write(ord[j], vals[ord[j]]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of transactions with random gaps, fed from goal_q
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && !holding) begin
      if (gap_left > 0) begin
        gap_left--;
        start   <= 1'b0;
        // junk on the payload while start is low
        goal_x  <= 24'($urandom);
        goal_y  <= 24'($urandom);
        heading <= 16'($urandom);
      end else if (goal_q.size() > 0) begin
        cur_goal = goal_q.pop_front();
        goal_x  <= cur_goal.gx;
        goal_y  <= cur_goal.gy;
        heading <= cur_goal.hd;
        start   <= 1'b1;
        holding = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // now and then a long burst with no idling at all
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on acceptance, check each strobe against the oldest
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        accepted_cmd.goal = cur_goal;
        accepted_cmd.cmd  = steer_command(cur_goal);
        cmd_q.push_back(accepted_cmd);
        holding = 1'b0;
        n_items++;
      end
      if (done) begin
        if (cmd_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected: speed %0d rate %0d bearing %0d",
                                    res_speed, res_rate, res_bearing));
        end else begin
          oldest = cmd_q.pop_front();
          if (res_speed !== oldest.cmd.speed)
            report_mismatch($sformatf("forward_speed %0d, want %0d (x %0d y %0d h %0d)",
                                      res_speed, oldest.cmd.speed, oldest.goal.gx,
                                      oldest.goal.gy, oldest.goal.hd));
          if (res_rate !== oldest.cmd.rate)
            report_mismatch($sformatf("turn_rate %0d, want %0d (x %0d y %0d h %0d)",
                                      res_rate, oldest.cmd.rate, oldest.goal.gx,
                                      oldest.goal.gy, oldest.goal.hd));
          if (res_bearing !== oldest.cmd.bearing)
            report_mismatch($sformatf("bearing %0d, want %0d (x %0d y %0d)",
                                      res_bearing, oldest.cmd.bearing, oldest.goal.gx,
                                      oldest.goal.gy));
          n_results++;
          if (oldest.cmd.speed == 16'd0) n_stopped++;
        end
      end
    end
  end

  // watchdog: too long with no transaction of any kind
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
               idle_cycles, cmd_q.size());
      $display("[heading_p_controller] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed goals at the reset register values
    push_goal(0, 0, 0);                       // goal at origin
    push_goal(0, 0, -32768);                  // origin, error of minus pi
    push_goal(0, 0, 32767);
    push_goal(1, 0, 0);
    push_goal(-1, 0, 0);                      // negative x axis, bearing -pi
    push_goal(-8388608, 0, 0);
    push_goal(-8388608, 0, -32768);
    push_goal(8388607, 0, 0);
    push_goal(0, 8388607, 16384);
    push_goal(0, -8388608, -16384);
    push_goal(8388607, 8388607, 0);
    push_goal(-8388608, -8388608, 0);
    push_goal(-8388608, 8388607, 32767);
    push_goal(8388607, -8388608, -32768);
    push_goal(-1, -1, -32768);
    push_goal(1, 1, 32767);
    push_goal(-5, 3, -20000);
    push_goal(3, -5, 20000);
    push_goal(0, 1, 16384 + 5461);
    push_goal(0, 1, 16384 - 5461);
    for (int k = 0; k < WARMUP_ITEMS; k++) goal_q.push_back(random_goal());
    wait_drained();

    // each phase drains completely before its registers change
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      for (int k = 0; k < PHASE_ITEMS; k++) goal_q.push_back(random_goal());
      wait_drained();
    end

    // stray strobes after the last expected result
    repeat (PIPE_LATENCY + 5) @(posedge clk);

    $display("covered %0d goal transactions over %0d register settings (%0d writes)",
             n_items, NUM_PHASES + 1, n_cfg_writes);
    $display("checked %0d results, %0d with forward speed held at zero, %0d mismatches",
             n_results, n_stopped, n_errors);
    if (n_errors == 0 && cmd_q.size() == 0) begin
      $display("[heading_p_controller] OK");
    end else begin
      $display("[heading_p_controller] ERROR");
    end
    $finish;
  end

endmodule

FILE: heading_p_controller.f
sv/hpc_pkg.sv
sv/hpc_cordic_cell.sv
sv/hpc_output_stage.sv
sv/heading_p_controller.sv
tb/sv/tb_top.sv
